### rtl/dda_pkg.sv
// Shared types and constants for the DDA line point generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dda_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_BITS   = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_START_X = 2'd0,
		CFG_START_Y = 2'd1,
		CFG_END_X   = 2'd2,
		CFG_END_Y   = 2'd3
	} cfg_reg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic setup;     // latch deltas, step count and start point
		logic div_step;  // one restoring division step on both axes
		logic div_first; // first step: integer quotient bit, no shift
		logic finish;    // sign the quotients into the increments
		logic advance;   // step the accumulators and load the output word
	} dp_cmd_t;

	typedef struct packed {
		logic active;    // steps remain on the current line
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/dda_if.sv
// Valid/ready channel interfaces: input item, output point and config write.
// Depends on dda_pkg for the register index width and the default widths.
`default_nettype none

interface dda_item_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface dda_point_if
	import dda_pkg::*;
#(
	parameter int ACC_BITS = COORD_BITS_DEF + FRAC_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [ACC_BITS-1:0] point_x;
	logic signed [ACC_BITS-1:0] point_y;
	logic                       last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

interface dda_cfg_if
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [CFG_IDX_BITS-1:0]      index;
	logic signed [COORD_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/dda_ctrl.sv
// Controller for the DDA line point generator: handshakes, division sequencing,
// output word valid. Depends on dda_pkg; drives dda_dp through dp_cmd_t.
`default_nettype none

module dda_ctrl
	import dda_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic       item_advance,
	output logic            point_valid,
	input  wire logic       point_ready,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	localparam int CNT_BITS = $clog2(FRAC_BITS + 2);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic                out_valid_q;
	logic                accept;

	assign item_ready  = (state_q == S_IDLE) && (!out_valid_q || point_ready);
	assign accept      = item_valid && item_ready;
	assign point_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!item_advance) begin
						cmd.setup = 1'b1;
						cnt_d     = '0;
						state_d   = S_DIV;
					end else if (status.active) begin
						cmd.advance = 1'b1;
					end
				end
			end
			S_DIV: begin
				// one integer bit then FRAC_BITS fraction bits
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(FRAC_BITS)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (point_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/dda_dp.sv
// Datapath for the DDA line point generator: endpoint registers, step count,
// two restoring dividers, accumulators and output word. Depends on dda_pkg.
`default_nettype none

module dda_dp
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]            cfg_index,
	input  wire logic signed [COORD_BITS-1:0]       cfg_data,
	input  wire dp_cmd_t                            cmd,
	output dp_status_t                              status,
	output logic signed [COORD_BITS+FRAC_BITS-1:0]  point_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0]  point_y,
	output logic                                    last_point
);

	localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
	localparam int INC_BITS  = FRAC_BITS + 2;
	localparam int STEP_BITS = COORD_BITS + 1;
	localparam int QUO_BITS  = FRAC_BITS + 1;

	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic signed [ACC_BITS-1:0]   acc_x_q, acc_y_q;
	logic signed [INC_BITS-1:0]   inc_x_q, inc_y_q;
	logic [STEP_BITS-1:0]         steps_left_q;
	logic [STEP_BITS-1:0]         steps_q;
	logic [STEP_BITS-1:0]         rem_x_q, rem_y_q;
	logic [QUO_BITS-1:0]          quo_x_q, quo_y_q;
	logic                         neg_x_q, neg_y_q;
	logic signed [ACC_BITS-1:0]   point_x_q, point_y_q;
	logic                         last_q;

	logic signed [STEP_BITS-1:0]  dx, dy;
	logic [STEP_BITS-1:0]         mag_x, mag_y, steps;
	logic [STEP_BITS-1:0]         trial_x, trial_y, rem_x_d, rem_y_d;
	logic                         ge_x, ge_y;
	logic signed [ACC_BITS-1:0]   sum_x, sum_y;

	// deltas, magnitudes and the step count
	assign dx    = {end_x_q[COORD_BITS-1], end_x_q} - {start_x_q[COORD_BITS-1], start_x_q};
	assign dy    = {end_y_q[COORD_BITS-1], end_y_q} - {start_y_q[COORD_BITS-1], start_y_q};
	assign mag_x = dx[STEP_BITS-1] ? STEP_BITS'(-dx) : STEP_BITS'(dx);
	assign mag_y = dy[STEP_BITS-1] ? STEP_BITS'(-dy) : STEP_BITS'(dy);
	assign steps = (mag_x > mag_y) ? mag_x : mag_y;

	// restoring division; the remainder stays below steps, so the shift fits
	assign trial_x = cmd.div_first ? rem_x_q : {rem_x_q[STEP_BITS-2:0], 1'b0};
	assign trial_y = cmd.div_first ? rem_y_q : {rem_y_q[STEP_BITS-2:0], 1'b0};
	assign ge_x    = trial_x >= steps_q;
	assign ge_y    = trial_y >= steps_q;
	assign rem_x_d = ge_x ? trial_x - steps_q : trial_x;
	assign rem_y_d = ge_y ? trial_y - steps_q : trial_y;

	assign sum_x = acc_x_q + {{(ACC_BITS-INC_BITS){inc_x_q[INC_BITS-1]}}, inc_x_q};
	assign sum_y = acc_y_q + {{(ACC_BITS-INC_BITS){inc_y_q[INC_BITS-1]}}, inc_y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= '0;
			start_y_q    <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			inc_x_q      <= '0;
			inc_y_q      <= '0;
			steps_left_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_START_X: start_x_q <= cfg_data;
					CFG_START_Y: start_y_q <= cfg_data;
					CFG_END_X:   end_x_q   <= cfg_data;
					CFG_END_Y:   end_y_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.setup) begin
				acc_x_q <= {start_x_q, {FRAC_BITS{1'b0}}};
				acc_y_q <= {start_y_q, {FRAC_BITS{1'b0}}};
			end else if (cmd.advance) begin
				acc_x_q      <= sum_x;
				acc_y_q      <= sum_y;
				steps_left_q <= steps_left_q - 1'b1;
			end
			if (cmd.finish) begin
				// zero-length line: no increments, no active steps
				if (steps_q == '0) begin
					inc_x_q <= '0;
					inc_y_q <= '0;
				end else begin
					inc_x_q <= neg_x_q ? -INC_BITS'({1'b0, quo_x_q}) : INC_BITS'({1'b0, quo_x_q});
					inc_y_q <= neg_y_q ? -INC_BITS'({1'b0, quo_y_q}) : INC_BITS'({1'b0, quo_y_q});
				end
				steps_left_q <= steps_q;
			end
		end
	end

	// division working registers and output word
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			rem_x_q <= mag_x;
			rem_y_q <= mag_y;
			neg_x_q <= dx[STEP_BITS-1];
			neg_y_q <= dy[STEP_BITS-1];
			steps_q <= steps;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (cmd.div_step) begin
			rem_x_q <= rem_x_d;
			rem_y_q <= rem_y_d;
			quo_x_q <= {quo_x_q[QUO_BITS-2:0], ge_x};
			quo_y_q <= {quo_y_q[QUO_BITS-2:0], ge_y};
		end
		if (cmd.advance) begin
			point_x_q <= sum_x;
			point_y_q <= sum_y;
			last_q    <= (steps_left_q == STEP_BITS'(1));
		end
	end

	assign status.active = (steps_left_q != '0);
	assign point_x       = point_x_q;
	assign point_y       = point_y_q;
	assign last_point    = last_q;

endmodule

`default_nettype wire

### rtl/dda_line_point_generator_core.sv
// Top level of the DDA line point generator: controller plus datapath.
// Depends on dda_pkg, the channel interfaces in dda_if, dda_ctrl and dda_dp.
//
//   channel  dir  payload                          accepted when
//   item     in   advance                          item.valid && item.ready
//   point    out  point_x, point_y, last_point     point.valid && point.ready
//   cfg      in   index, data                      cfg.valid && cfg.ready
//
// Points stream at one per cycle while the output word is taken. A rewind
// latches the deltas, runs FRAC_BITS + 1 restoring division steps, then
// signs the increments.
// Reset (arst_n low) clears the endpoints, accumulators and step count.
// The item side stalls during a rewind and while a point waits and the point
// side does not take it. cfg is always ready.
`default_nettype none

module dda_line_point_generator_core
	import dda_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	dda_item_if.sink   item,
	dda_point_if.source point,
	dda_cfg_if.sink    cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	dda_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.item_advance(item.advance),
		.point_valid (point.valid),
		.point_ready (point.ready),
		.cmd         (cmd),
		.status      (status)
	);

	dda_dp #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.status    (status),
		.point_x   (point.point_x),
		.point_y   (point.point_y),
		.last_point(point.last_point)
	);

endmodule

`default_nettype wire
